// ===== design/sat_pkg.sv =====
`timescale 1ns / 1ps

package sat_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned CAPACITY_DEF  = 64;
  localparam int unsigned KEY_WIDTH_DEF = 32;

  // Fixed widths of the item fields.
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_DELETE = 3'd1,
    MODE_LOOKUP = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_REWIND = 3'd4,
    MODE_NEXT   = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_ABSENT   = 2'd2,
    STATUS_PAST_END = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  count;
    logic                full_res;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic ins_en;
    logic del_en;
  } cell_cmd_t;

  // Compare flags that each cell reports.
  typedef struct packed {
    logic gt;  // cell is occupied and the search key is above its entry
    logic eq;  // cell is occupied and its entry equals the search key
  } cell_flag_t;

endpackage

// ===== design/sorted_array_table.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Signals                          | Payload
// --------+-----------+----------------------------------+---------------------------------
// in      | input     | in_valid_i, in_ready_o           | in_item_i  (mode, key)
// out     | output    | out_valid_o, out_ready_i         | out_item_o (found, value, count,
//         |           |                                  |             full_res, status)
//
// Each item is first captured and then executed: all cells compare against
// the key and update in parallel. The block takes no new item until the
// current one has executed.
// The result goes to an output register; the next item is taken while that
// result still waits. An item in execution holds when the output register is
// occupied and not being drained.
// Reset clears the entry count, the cursor and the control state; the cells
// themselves are not cleared, since only slots below the count are read.
module sorted_array_table #(
  parameter int unsigned CAPACITY  = sat_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_WIDTH = sat_pkg::KEY_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sat_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sat_pkg::out_item_t out_item_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  sat_pkg::state_e    state_q, state_d;
  sat_pkg::in_item_t  op_q;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    cursor_q, cursor_d;
  sat_pkg::out_item_t out_q, res;
  logic               out_valid_q, out_valid_d;

  logic               accept;
  logic               exec_go;
  logic [KEY_WIDTH-1:0] key_w;
  logic [KEY_WIDTH-1:0] read_val;
  logic               any_eq;
  logic               full_now;
  sat_pkg::cell_cmd_t cmd;

  logic [KEY_WIDTH-1:0] keys [CAPACITY];
  sat_pkg::cell_flag_t  flags [CAPACITY];
  logic [CAPACITY-1:0]  eq_vec;

  assign accept  = in_valid_i && in_ready_o;
  assign exec_go = (state_q == sat_pkg::ST_EXEC) && (!out_valid_q || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sat_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = sat_pkg::ST_EXEC;
        end
      end
      sat_pkg::ST_EXEC: begin
        if (exec_go) begin
          state_d = sat_pkg::ST_IDLE;
        end
      end
      default: state_d = sat_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready_o = 1'b0;
    case (state_q)
      sat_pkg::ST_IDLE: in_ready_o = 1'b1;
      sat_pkg::ST_EXEC: in_ready_o = 1'b0;
      default:          in_ready_o = 1'b0;
    endcase
  end

  // Keys are taken modulo 2^KEY_WIDTH.
  assign key_w    = KEY_WIDTH'(op_q.key);
  assign full_now = (count_q == CntW'(CAPACITY));

  // The row of cells. Cell 0 sees a left neighbor whose gt flag is set, so it
  // takes the key when no stored entry is below it. The last cell pulls in
  // zero on delete; that slot is beyond the count afterwards.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] left_key, right_key;
    logic                 left_gt;

    if (i == 0) begin : g_first
      assign left_key = '0;
      assign left_gt  = 1'b1;
    end else begin : g_mid
      assign left_key = keys[i-1];
      assign left_gt  = flags[i-1].gt;
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = '0;
    end else begin : g_inner
      assign right_key = keys[i+1];
    end

    sat_cell #(
      .KEY_WIDTH(KEY_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .key_i       (key_w),
      .cmd_i       (cmd),
      .occupied_i  (CntW'(i) < count_q),
      .left_key_i  (left_key),
      .left_gt_i   (left_gt),
      .right_key_i (right_key),
      .key_o       (keys[i]),
      .flag_o      (flags[i])
    );

    assign eq_vec[i] = flags[i].eq;
  end

  assign any_eq = |eq_vec;

  // The cell under the cursor drives the read-next value.
  always_comb begin
    read_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cursor_q == CntW'(i)) begin
        read_val = read_val | keys[i];
      end
    end
  end

  // Operation decode, cell commands and the result.
  always_comb begin
    cmd.ins_en   = 1'b0;
    cmd.del_en   = 1'b0;
    count_d      = count_q;
    cursor_d     = cursor_q;
    res.found    = 1'b0;
    res.value    = '0;
    res.status   = sat_pkg::STATUS_OK;

    case (sat_pkg::mode_e'(op_q.mode))
      sat_pkg::MODE_INSERT: begin
        if (full_now) begin
          res.status = sat_pkg::STATUS_FULL;
        end else begin
          cmd.ins_en = exec_go;
          count_d    = count_q + CntW'(1);
        end
      end
      sat_pkg::MODE_DELETE: begin
        if (any_eq) begin
          cmd.del_en = exec_go;
          count_d    = count_q - CntW'(1);
          res.found  = 1'b1;
        end else begin
          res.status = sat_pkg::STATUS_ABSENT;
        end
      end
      sat_pkg::MODE_LOOKUP: begin
        // A hit returns the stored entry, which equals the key.
        if (any_eq) begin
          res.found = 1'b1;
          res.value = sat_pkg::VALUE_W'(key_w);
        end else begin
          res.status = sat_pkg::STATUS_ABSENT;
        end
      end
      sat_pkg::MODE_CLEAR: begin
        count_d = '0;
      end
      sat_pkg::MODE_REWIND: begin
        cursor_d = '0;
      end
      sat_pkg::MODE_NEXT: begin
        if (cursor_q >= count_q) begin
          res.status = sat_pkg::STATUS_PAST_END;
        end else begin
          res.value = sat_pkg::VALUE_W'(read_val);
          cursor_d  = cursor_q + CntW'(1);
        end
      end
      default: begin
        // Unused modes change nothing.
      end
    endcase

    res.count    = sat_pkg::COUNT_W'(count_d);
    res.full_res = (count_d == CntW'(CAPACITY));
  end

  // Output register: loaded when an item completes, freed when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (exec_go) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sat_pkg::ST_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (exec_go) begin
        count_q  <= count_d;
        cursor_q <= cursor_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_item_i;
    end
    if (exec_go) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== design/sat_cell.sv =====
`timescale 1ns / 1ps

// One slot of the sorted table. It compares its entry with the broadcast key
// and, on insert or delete, either keeps its entry, takes the new key, or
// takes the entry of its left or right neighbor.
module sat_cell #(
  parameter int unsigned KEY_WIDTH = sat_pkg::KEY_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic [KEY_WIDTH-1:0]  key_i,
  input  sat_pkg::cell_cmd_t    cmd_i,
  input  logic                  occupied_i,
  input  logic [KEY_WIDTH-1:0]  left_key_i,
  input  logic                  left_gt_i,
  input  logic [KEY_WIDTH-1:0]  right_key_i,
  output logic [KEY_WIDTH-1:0]  key_o,
  output sat_pkg::cell_flag_t   flag_o
);

  logic [KEY_WIDTH-1:0] entry_q, entry_d;

  always_comb begin
    flag_o.gt = occupied_i && (key_i > entry_q);
    flag_o.eq = occupied_i && (key_i == entry_q);
  end

  // Sorted order means the cells with gt set form a prefix. On insert the
  // first cell outside that prefix takes the key and the rest shift up. On
  // delete every cell outside the prefix takes its right neighbor, which
  // removes the first equal entry.
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins_en && !flag_o.gt) begin
      entry_d = left_gt_i ? key_i : left_key_i;
    end else if (cmd_i.del_en && !flag_o.gt) begin
      entry_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign key_o = entry_q;

endmodule

// ===== sim/sorted_array_table_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the sorted key table. A predictor inside the bench
// keeps its own copy of the ordered keys, the entry count and the walk cursor.
// It works out the reply to every item at the edge where the block takes it,
// and one checker process compares each reply taken from the block with the
// oldest reply still waiting.
module sorted_array_table_tb;

  localparam int unsigned CAP        = sat_pkg::CAPACITY_DEF;
  localparam int unsigned RUN_LIMIT  = 200000;
  localparam int unsigned DRAIN_WAIT = 20;
  localparam int unsigned HOLD_LEN   = 300;

  // Modes 6 and 7 have no name in the package. The block must answer them
  // with an empty reply and leave all of its state alone.
  localparam logic [sat_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [sat_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  sat_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  sat_pkg::out_item_t out_item;

  // The predicted table: sorted keys, the number in use and the walk cursor.
  logic [sat_pkg::KEY_W-1:0] key_store [CAP];
  int unsigned               key_count = 0;
  int unsigned               walk_pos = 0;

  sat_pkg::out_item_t expected_replies[$];
  int unsigned        error_count = 0;
  int unsigned        cycle_count = 0;
  int unsigned        hold_left = 0;
  bit                 tx_gaps_on = 1'b1;
  bit                 rx_gaps_on = 1'b1;

  sorted_array_table dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always #2 clk = ~clk;

  // Applies one item to the predicted table and returns the reply it gives.
  function automatic sat_pkg::out_item_t apply_table_op(sat_pkg::in_item_t item);
    sat_pkg::out_item_t r;
    int unsigned        pos;
    int unsigned        i;
    bit                 hit;
    r = '0;
    r.status = sat_pkg::STATUS_OK;
    case (item.mode)
      sat_pkg::MODE_INSERT: begin
        if (key_count >= CAP) begin
          r.status = sat_pkg::STATUS_FULL;
        end else begin
          // An equal key goes in front of the first stored copy.
          pos = 0;
          while (pos < key_count && item.key > key_store[pos]) pos++;
          for (i = key_count; i > pos; i--) key_store[i] = key_store[i-1];
          key_store[pos] = item.key;
          key_count++;
        end
      end
      sat_pkg::MODE_DELETE: begin
        pos = 0;
        while (pos < key_count && key_store[pos] != item.key) pos++;
        if (pos >= key_count) begin
          r.status = sat_pkg::STATUS_ABSENT;
        end else begin
          for (i = pos + 1; i < key_count; i++) key_store[i-1] = key_store[i];
          key_count--;
          r.found = 1'b1;
        end
      end
      sat_pkg::MODE_LOOKUP: begin
        // Any stored copy equals the key, so a plain scan gives the same
        // answer as a search by halving.
        hit = 1'b0;
        for (i = 0; i < key_count; i++) begin
          if (key_store[i] == item.key) hit = 1'b1;
        end
        if (hit) begin
          r.found = 1'b1;
          r.value = item.key;
        end else begin
          r.status = sat_pkg::STATUS_ABSENT;
        end
      end
      sat_pkg::MODE_CLEAR: begin
        // The cursor stays where it is, even when it now lies past the end.
        key_count = 0;
      end
      sat_pkg::MODE_REWIND: begin
        walk_pos = 0;
      end
      sat_pkg::MODE_NEXT: begin
        if (walk_pos >= key_count) begin
          r.status = sat_pkg::STATUS_PAST_END;
        end else begin
          r.value = key_store[walk_pos];
          walk_pos++;
        end
      end
      default: begin
      end
    endcase
    r.count = key_count[sat_pkg::COUNT_W-1:0];
    r.full_res = (key_count == CAP);
    return r;
  endfunction

  // Offers one item, possibly after a few idle cycles, and holds it until the
  // block takes it. The reply is predicted at the edge of acceptance. Valid
  // stays high on return so that a following item can go out back to back.
  task automatic send_item(input logic [sat_pkg::MODE_W-1:0] op,
                           input logic [sat_pkg::KEY_W-1:0]  key);
    sat_pkg::in_item_t item;
    item.mode = op;
    item.key = key;
    if (tx_gaps_on) begin
      while ($urandom_range(99) < 20) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (!in_ready);
    expected_replies.push_back(apply_table_op(item));
  endtask

  // Drops valid and waits until every predicted reply has come back. It waits
  // for a clock edge first, so valid is never driven twice in one step.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_replies.size() != 0);
  endtask

  // Key choice for random items: most often keys already stored, so deletes and
  // lookups hit, then a small range that breeds duplicates, the extremes of
  // the field, and fully random keys that move every bit.
  function automatic logic [sat_pkg::KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45 && key_count > 0) return key_store[$urandom_range(key_count - 1)];
    if (r < 75) return sat_pkg::KEY_W'($urandom_range(15));
    if (r < 85) begin
      case ($urandom_range(3))
        0: return '0;
        1: return '1;
        2: return {1'b1, {(sat_pkg::KEY_W-1){1'b0}}};
        default: return {1'b0, {(sat_pkg::KEY_W-1){1'b1}}};
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [sat_pkg::MODE_W-1:0] pick_mode();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return sat_pkg::MODE_INSERT;
    if (r < 55) return sat_pkg::MODE_DELETE;
    if (r < 75) return sat_pkg::MODE_LOOKUP;
    if (r < 88) return sat_pkg::MODE_NEXT;
    if (r < 94) return sat_pkg::MODE_REWIND;
    if (r < 96) return sat_pkg::MODE_CLEAR;
    if (r < 98) return MODE_SPARE_A;
    return MODE_SPARE_B;
  endfunction

  // Extremes of the key, duplicates, hits and misses, every mode, and the
  // walk running past the end before and after the table changes under it.
  task automatic test_directed();
    send_item(sat_pkg::MODE_INSERT, 32'h8000_0000);
    send_item(sat_pkg::MODE_INSERT, 32'h0000_0000);
    send_item(sat_pkg::MODE_INSERT, 32'hFFFF_FFFF);
    send_item(sat_pkg::MODE_INSERT, 32'h8000_0000);
    send_item(sat_pkg::MODE_LOOKUP, 32'h8000_0000);
    send_item(sat_pkg::MODE_LOOKUP, 32'h0000_0000);
    send_item(sat_pkg::MODE_LOOKUP, 32'hFFFF_FFFF);
    send_item(sat_pkg::MODE_LOOKUP, 32'h0000_0005);
    send_item(sat_pkg::MODE_DELETE, 32'h0000_0005);
    send_item(sat_pkg::MODE_DELETE, 32'h8000_0000);
    send_item(sat_pkg::MODE_LOOKUP, 32'h8000_0000);
    send_item(sat_pkg::MODE_REWIND, 32'hFFFF_FFFF);
    send_item(sat_pkg::MODE_NEXT, 32'h0);
    send_item(sat_pkg::MODE_NEXT, 32'hFFFF_FFFF);
    send_item(sat_pkg::MODE_NEXT, 32'h0);
    send_item(sat_pkg::MODE_NEXT, 32'h0);
    // Growing the table under a finished walk lets the cursor read again.
    send_item(sat_pkg::MODE_INSERT, 32'h0000_0001);
    send_item(sat_pkg::MODE_NEXT, 32'h0);
    send_item(MODE_SPARE_A, 32'hFFFF_FFFF);
    send_item(MODE_SPARE_B, 32'h1234_5678);
    send_item(sat_pkg::MODE_CLEAR, 32'hFFFF_FFFF);
    send_item(sat_pkg::MODE_NEXT, 32'h0);
    send_item(sat_pkg::MODE_LOOKUP, 32'h0000_0000);
    send_item(sat_pkg::MODE_DELETE, 32'h0000_0000);
    send_item(sat_pkg::MODE_REWIND, 32'h0);
    wait_drained();
  endtask

  // Fills the table to capacity, runs into the full case, walks every key in
  // order and off the end, then empties the table again.
  task automatic test_fill_and_walk();
    int unsigned n;
    send_item(sat_pkg::MODE_CLEAR, $urandom());
    send_item(sat_pkg::MODE_REWIND, $urandom());
    for (n = 0; n < CAP + 3; n++) send_item(sat_pkg::MODE_INSERT, pick_key());
    send_item(sat_pkg::MODE_REWIND, $urandom());
    for (n = 0; n < CAP + 2; n++) send_item(sat_pkg::MODE_NEXT, $urandom());
    for (n = 0; n < 6; n++) send_item(sat_pkg::MODE_LOOKUP, pick_key());
    for (n = 0; n < 6; n++) send_item(sat_pkg::MODE_DELETE, pick_key());
    send_item(sat_pkg::MODE_CLEAR, $urandom());
  endtask

  task automatic test_random_mix(input int unsigned items);
    int unsigned n;
    for (n = 0; n < items; n++) send_item(pick_mode(), pick_key());
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // block fills up and stops taking items. The sender then pauses until every
  // reply is back.
  task automatic test_backpressure();
    int unsigned n;
    hold_left <= HOLD_LEN;
    for (n = 0; n < 12; n++) send_item(pick_mode(), pick_key());
    wait_drained();
  endtask

  // Neither side idles here, so the block runs at its full rate.
  task automatic test_full_rate(input int unsigned items);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    test_random_mix(items);
    wait_drained();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  task automatic check_reply(input sat_pkg::out_item_t got);
    sat_pkg::out_item_t exp;
    if (expected_replies.size() == 0) begin
      $error("reply with none expected: found=%0d value=%0h count=%0d full_res=%0d status=%0d",
             got.found, got.value, got.count, got.full_res, got.status);
      error_count++;
      return;
    end
    exp = expected_replies.pop_front();
    if (got.found !== exp.found) begin
      $error("found: expected %0d, actual %0d", exp.found, got.found);
      error_count++;
    end
    if (got.value !== exp.value) begin
      $error("value: expected %0h, actual %0h", exp.value, got.value);
      error_count++;
    end
    if (got.count !== exp.count) begin
      $error("count: expected %0d, actual %0d", exp.count, got.count);
      error_count++;
    end
    if (got.full_res !== exp.full_res) begin
      $error("full_res: expected %0d, actual %0d", exp.full_res, got.full_res);
      error_count++;
    end
    if (got.status !== exp.status) begin
      $error("status: expected %0d, actual %0d", exp.status, got.status);
      error_count++;
    end
  endtask

  // Receiver: takes replies at the edge and chooses ready for the next cycle.
  // Ready stays low while a hold-off runs, and otherwise drops at random when
  // idling is allowed.
  always @(posedge clk) begin
    if (out_valid && out_ready) check_reply(out_item);
    if (hold_left != 0) begin
      out_ready <= 1'b0;
    end else if (rx_gaps_on) begin
      out_ready <= ($urandom_range(99) >= 20);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // The hold-off is counted down in cycles here.
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("sorted_array_table_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fill_and_walk();
    test_random_mix(200);
    test_backpressure();
    test_full_rate(60);
    wait_drained();
    // A late reply with nothing expected would show up in this window.
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("sorted_array_table_tb OK");
    end else begin
      $display("sorted_array_table_tb NOT OK");
    end
    $finish;
  end

endmodule
